// ===== rtl/core/pdu8_pkg.sv =====
package pdu8_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;

  // percent escape phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PCT  = 2'd1;
  localparam logic [1:0] PH_HEX  = 2'd2;

  localparam logic [BYTE_W-1:0] PCT_CHAR = 8'h25;

  // UTF-8 lead and continuation patterns
  localparam logic [BYTE_W-1:0] ASCII_LIM  = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;

  localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_2B  = 21'h000080;
  localparam logic [CP_W-1:0] MIN_3B  = 21'h000800;
  localparam logic [CP_W-1:0] MIN_4B  = 21'h010000;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/pdu8_in_if.sv =====
interface pdu8_in_if import pdu8_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              has_byte;
  logic              is_last;

  modport source (output valid, in_byte, has_byte, is_last, input ready);
  modport sink   (input valid, in_byte, has_byte, is_last, output ready);
endinterface

// ===== rtl/core/pdu8_out_if.sv =====
interface pdu8_out_if import pdu8_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_valid;
  logic              done_res;
  logic              status;

  modport source (output valid, out_byte, out_valid, done_res, status, input ready);
  modport sink   (input valid, out_byte, out_valid, done_res, status, output ready);
endinterface

// ===== rtl/core/percent_decode_utf8_check.sv =====
// Channel | Dir | Word contents
// --------+-----+-------------------------------------------------------
// in_i    | in  | in_byte[7:0], has_byte, is_last
// out_o   | out | out_byte[7:0], out_valid, done_res, status
//
// One word per cycle sustained while out_o.ready holds. An accepted word is held
// in the input register, the decode/UTF-8 update runs on it there, and the
// result lands in the output register.
// Reset (rst_ni low, async) clears all valid flags and decoder state.
// in_i.ready drops only when the output register is full and not taken.
// Non-last words that produce no result (a '%', a first or bad hex digit, or an
// empty word) still advance the state and occupy no output slot.
module percent_decode_utf8_check import pdu8_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pdu8_in_if.sink    in_i,
  pdu8_out_if.source out_o
);

  // input register
  logic              s1_vld_q;
  logic [BYTE_W-1:0] s1_byte_q;
  logic              s1_has_q;
  logic              s1_last_q;

  // decoder state
  logic [1:0]      phase_q, phase_d;
  logic [3:0]      nib_q, nib_d;
  logic [1:0]      cont_q, cont_d;
  logic [1:0]      seq_q, seq_d;
  logic [CP_W-1:0] cp_q, cp_d;
  logic            err_q, err_d;

  // output register
  logic              o_vld_q;
  logic [BYTE_W-1:0] o_byte_q;
  logic              o_bvld_q;
  logic              o_done_q;
  logic              o_stat_q;

  logic              s1_adv;
  logic              emit;
  logic [BYTE_W-1:0] dec;
  logic [4:0]        hex;
  logic [CP_W-1:0]   cp_new;
  logic [CP_W-1:0]   cp_min;
  logic              fin_stat;
  logic              res_fire;

  assign s1_adv     = s1_vld_q && (!o_vld_q || out_o.ready);
  assign in_i.ready = !s1_vld_q || s1_adv;
  assign hex        = hex_decode(s1_byte_q);
  assign cp_new     = {cp_q[CP_W-7:0], dec[5:0]};

  always_comb begin
    priority if (seq_q == 2'd1) begin
      cp_min = MIN_2B;
    end else if (seq_q == 2'd2) begin
      cp_min = MIN_3B;
    end else begin
      cp_min = MIN_4B;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    nib_d    = nib_q;
    cont_d   = cont_q;
    seq_d    = seq_q;
    cp_d     = cp_q;
    err_d    = err_q;
    emit     = 1'b0;
    dec      = '0;
    fin_stat = 1'b0;

    // percent escape stage
    if (s1_has_q) begin
      unique case (phase_q)
        PH_PCT: begin
          if (hex[4]) begin
            nib_d   = hex[3:0];
            phase_d = PH_HEX;
          end else begin
            err_d   = 1'b1;
            phase_d = PH_IDLE;
          end
        end
        PH_HEX: begin
          if (hex[4]) begin
            dec  = {nib_q, hex[3:0]};
            emit = 1'b1;
          end else begin
            err_d = 1'b1;
          end
          phase_d = PH_IDLE;
        end
        default: begin
          // idle (the unused code behaves the same)
          if (s1_byte_q == PCT_CHAR) begin
            phase_d = PH_PCT;
          end else begin
            dec  = s1_byte_q;
            emit = 1'b1;
          end
        end
      endcase
    end

    // UTF-8 sequence tracking on the decoded byte
    if (emit) begin
      if (cont_q == 2'd0) begin
        if (dec < ASCII_LIM) begin
          // plain ASCII
        end else if ((dec & LEAD2_MASK) == LEAD2_TAG) begin
          cont_d = 2'd1;
          seq_d  = 2'd1;
          cp_d   = {16'd0, dec[4:0]};
        end else if ((dec & LEAD3_MASK) == LEAD3_TAG) begin
          cont_d = 2'd2;
          seq_d  = 2'd2;
          cp_d   = {17'd0, dec[3:0]};
        end else if ((dec & LEAD4_MASK) == LEAD4_TAG) begin
          cont_d = 2'd3;
          seq_d  = 2'd3;
          cp_d   = {18'd0, dec[2:0]};
        end else begin
          err_d = 1'b1;
        end
      end else if ((dec & CONT_MASK) != CONT_TAG) begin
        err_d  = 1'b1;
        cont_d = 2'd0;
      end else begin
        cp_d   = cp_new;
        cont_d = cont_q - 2'd1;
        // sequence complete: overlong, range and surrogate checks
        if (cont_q == 2'd1 &&
            (cp_new < cp_min || cp_new > CP_MAX ||
             (cp_new >= SURR_LO && cp_new <= SURR_HI))) begin
          err_d = 1'b1;
        end
      end
    end

    // end of string: pending escape or open sequence is an error
    if (s1_last_q) begin
      fin_stat = err_d || phase_d == PH_PCT || phase_d == PH_HEX || cont_d != 2'd0;
      phase_d  = PH_IDLE;
      nib_d    = '0;
      cont_d   = '0;
      seq_d    = '0;
      cp_d     = '0;
      err_d    = 1'b0;
    end
  end

  assign res_fire = emit || s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.in_byte;
      s1_has_q  <= in_i.has_byte;
      s1_last_q <= in_i.is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      nib_q   <= '0;
      cont_q  <= '0;
      seq_q   <= '0;
      cp_q    <= '0;
      err_q   <= 1'b0;
    end else if (s1_adv) begin
      phase_q <= phase_d;
      nib_q   <= nib_d;
      cont_q  <= cont_d;
      seq_q   <= seq_d;
      cp_q    <= cp_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (s1_adv && res_fire) begin
      o_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      o_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && res_fire) begin
      o_byte_q <= dec;
      o_bvld_q <= emit;
      o_done_q <= s1_last_q;
      o_stat_q <= fin_stat;
    end
  end

  assign out_o.valid     = o_vld_q;
  assign out_o.out_byte  = o_byte_q;
  assign out_o.out_valid = o_bvld_q;
  assign out_o.done_res  = o_done_q;
  assign out_o.status    = o_stat_q;

  // a word with no decoded byte exists only to report the end of string
  a_empty_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.out_valid |-> out_o.done_res)
    else $error("result without byte and without done");

  a_status_at_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status |-> out_o.done_res)
    else $error("status raised before end of string");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |=> phase_q == PH_IDLE && cont_q == 2'd0 && !err_q)
    else $error("decoder state not cleared after end of string");

  a_seq_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cont_q != 2'd0 |-> seq_q != 2'd0 && cont_q <= seq_q)
    else $error("continuation count outside sequence length");

endmodule
